// ----- rtl/kyber_ntt_forward_inverse_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef KYBER_NTT_FORWARD_INVERSE_TOP_ASSERT_SVH
`define KYBER_NTT_FORWARD_INVERSE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define KNT_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KNT_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");
`endif

// ----- rtl/knt_pkg.sv -----
// Package with types, constants and twiddle table for the NTT block.
package knt_pkg;
	localparam int COEFFS = 256;
	localparam logic [11:0] MOD_Q = 12'd3329;
	localparam logic [11:0] INV_128 = 12'd3303;
	// floor(2^24 / 3329), the reciprocal used by the reduction after a product.
	localparam logic [12:0] BARRETT_M = 13'd5039;
	// Last wait count of the three-stage modular multiplier.
	localparam logic [1:0] MUL_WAIT = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FWD   = 2'd1,
		OP_INV   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_LD_B,
		ST_OPS,
		ST_BF_MUL,
		ST_WR_A,
		ST_WR_B,
		ST_SC_RD,
		ST_SC_LD,
		ST_SC_MUL,
		ST_SC_WR,
		ST_DONE
	} state_t;

	function automatic logic [11:0] mod_mul(input logic [11:0] a, input logic [11:0] b);
		logic [23:0] p;
		p = a * b;
		return 12'(p % 24'(MOD_Q));
	endfunction

	function automatic logic [11:0] twiddle(input logic [6:0] i);
		logic [6:0] rev;
		logic [11:0] pw;
		for (int b = 0; b < 7; b++) rev[6 - b] = i[b];
		pw = 12'd1;
		for (int e = 0; e < 128; e++) if (e < int'(rev)) pw = mod_mul(pw, 12'd17);
		return pw;
	endfunction
endpackage

// ----- rtl/knt_ram.sv -----
// Generic single-port RAM with registered read.
module knt_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ----- rtl/knt_rom.sv -----
// Registered twiddle ROM of the powers of 17 in bit-reversed order.
module knt_rom (
	input  logic        clk,
	input  logic [6:0]  addr,
	output logic [11:0] data_q
);
	import knt_pkg::*;
	logic [11:0] rom [128];
	always_comb begin
		for (int i = 0; i < 128; i++) rom[i] = twiddle(7'(i));
	end
	always_ff @(posedge clk) data_q <= rom[addr];
endmodule

// ----- rtl/kyber_ntt_forward_inverse_top.sv -----
// Top level of the ML-KEM NTT unit with coefficient memory and sequencer.
// This block holds one 256-coefficient polynomial mod 3329 in a single-port
// RAM with a registered read. A write folds a value of 3329 or more by one
// subtraction. A read passes its coefficient through the RAM read register
// and then the output register. A forward or inverse transform ignores the
// index and runs 896 butterflies, each made of two RAM reads, a state to
// capture the second operand, one to load the modular multiplier, the
// multiplier stages (product, reciprocal estimate, correction) and two RAM
// writes. The inverse then scales all 256 entries by 128^-1, one entry at a
// time. The one RAM port and the multiplier latency set the length of a
// transform. Every entry must have been written before it is read or before
// a transform runs. Results leave through an output register, and a new
// item is taken only once that register is free and no read is still in
// flight.
module kyber_ntt_forward_inverse_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  index,
	input  logic [11:0] coeff_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] coeff_out,
	output logic        result_kind
);
	import knt_pkg::*;
	localparam int AW = $clog2(COEFFS);

	state_t        st_q, st_d;
	logic          inv_q;
	logic [2:0]    layer_q;
	logic [AW-2:0] bf_q;
	logic [AW-1:0] sc_q;
	logic [1:0]    wait_q;
	logic [11:0]   a_q, b_q;
	logic [11:0]   mx_q, my_q;
	logic [23:0]   prod_s1, prod_s2;
	logic [12:0]   quot_s2;
	logic [11:0]   res_s3;
	logic [11:0]   ov_q;
	logic          ov_v_q, rd_pend_q, kind_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [11:0]   wdata, rdata, zeta;
	logic [6:0]    k;

	// Layer length and butterfly index arithmetic. Forward layers start at
	// twiddle 2^layer, inverse layers count down from 128 >> layer, less one.
	logic [2:0]    sh;
	logic [AW-1:0] len, ja, jb, grp;
	always_comb begin
		sh  = inv_q ? 3'(layer_q + 3'd1) : 3'(3'd7 - layer_q);
		len = AW'(1) << sh;
		grp = AW'({1'b0, bf_q} >> sh);
		ja  = AW'((grp << (sh + 3'd1)) | ({1'b0, bf_q} & (len - 1'b1)));
		jb  = ja | len;
		k   = inv_q ? 7'((8'd128 >> layer_q) - 8'd1 - grp)
		            : 7'((7'd1 << layer_q) + 7'(grp));
	end

	knt_rom u_rom (.clk(clk), .addr(k), .data_q(zeta));
	knt_ram #(.WIDTH(12), .DEPTH(COEFFS)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

	// Modular multiplier: the product, then a reciprocal estimate of the
	// quotient, then one correcting subtraction. The operands stay in
	// mx_q and my_q, so the result holds steady once it has arrived.
	logic [36:0] qest;
	logic [23:0] qm, rem_full;
	logic [12:0] rem;
	assign qest     = {13'd0, prod_s1} * {24'd0, BARRETT_M};
	assign qm       = {11'd0, quot_s2} * {12'd0, MOD_Q};
	assign rem_full = prod_s2 - qm;
	assign rem      = rem_full[12:0];

	always_ff @(posedge clk) begin
		prod_s1 <= {12'd0, mx_q} * {12'd0, my_q};
		prod_s2 <= prod_s1;
		quot_s2 <= qest[36:24];
		res_s3  <= (rem >= 13'(MOD_Q)) ? 12'(rem - 13'(MOD_Q)) : rem[11:0];
	end

	// Forward butterflies combine a with the product, inverse ones with b.
	logic [11:0] sum, dif, cw;
	logic [12:0] s13, d13;
	always_comb begin
		s13 = {1'b0, a_q} + (inv_q ? {1'b0, b_q} : {1'b0, res_s3});
		sum = (s13 >= 13'(MOD_Q)) ? 12'(s13 - 13'(MOD_Q)) : s13[11:0];
		d13 = inv_q ? ({1'b0, b_q} + 13'(MOD_Q) - {1'b0, a_q})
		            : ({1'b0, a_q} + 13'(MOD_Q) - {1'b0, res_s3});
		dif = (d13 >= 13'(MOD_Q)) ? 12'(d13 - 13'(MOD_Q)) : d13[11:0];
		cw  = (coeff_in >= MOD_Q) ? 12'(coeff_in - MOD_Q) : coeff_in;
	end

	assign in_ready = (st_q == ST_IDLE) && !ov_v_q && !rd_pend_q;
	logic acc;
	assign acc = in_valid && in_ready;

	always_comb begin
		st_d = st_q; we = 1'b0; addr = index; wdata = cw;
		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					case (operation)
						OP_WRITE: we = 1'b1;
						OP_FWD, OP_INV: st_d = ST_RD_A;
						default: ;
					endcase
				end
			end
			ST_RD_A: begin addr = ja; st_d = ST_RD_B; end
			ST_RD_B: begin addr = jb; st_d = ST_LD_B; end
			ST_LD_B: begin addr = jb; st_d = ST_OPS; end
			ST_OPS: begin addr = ja; st_d = ST_BF_MUL; end
			ST_BF_MUL: begin
				addr = ja;
				if (wait_q == MUL_WAIT) st_d = ST_WR_A;
			end
			ST_WR_A: begin
				addr = ja; we = 1'b1; wdata = sum;
				st_d = ST_WR_B;
			end
			ST_WR_B: begin
				addr = jb; we = 1'b1; wdata = inv_q ? res_s3 : dif;
				if (&bf_q && layer_q == 3'd6) st_d = inv_q ? ST_SC_RD : ST_DONE;
				else st_d = ST_RD_A;
			end
			ST_SC_RD: begin addr = sc_q; st_d = ST_SC_LD; end
			ST_SC_LD: begin addr = sc_q; st_d = ST_SC_MUL; end
			ST_SC_MUL: begin
				addr = sc_q;
				if (wait_q == MUL_WAIT) st_d = ST_SC_WR;
			end
			ST_SC_WR: begin
				addr = sc_q; we = 1'b1; wdata = res_s3;
				st_d = (&sc_q) ? ST_DONE : ST_SC_RD;
			end
			ST_DONE: if (!ov_v_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; ov_v_q <= 1'b0; rd_pend_q <= 1'b0; ov_q <= '0; kind_q <= 1'b0;
			layer_q <= '0; bf_q <= '0; sc_q <= '0; wait_q <= '0; inv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			rd_pend_q <= acc && operation == OP_READ;
			if (rd_pend_q) begin
				ov_v_q <= 1'b1; ov_q <= rdata; kind_q <= 1'b0;
			end else if (st_q == ST_DONE && !ov_v_q) begin
				ov_v_q <= 1'b1; ov_q <= '0; kind_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				ov_v_q <= 1'b0;
			end
			if (acc && (operation == OP_FWD || operation == OP_INV)) begin
				inv_q <= (operation == OP_INV); layer_q <= '0; bf_q <= '0; sc_q <= '0;
			end
			if (st_q inside {ST_BF_MUL, ST_SC_MUL}) wait_q <= wait_q + 2'd1;
			else wait_q <= '0;
			if (st_q == ST_WR_B) begin
				bf_q <= bf_q + 1'b1;
				if (&bf_q) layer_q <= layer_q + 3'd1;
			end
			if (st_q == ST_SC_WR) sc_q <= sc_q + 1'b1;
		end
	end

	// Operand capture: a arrives after RD_B, b after LD_B; the multiplier
	// operands are loaded in OPS for a butterfly and in SC_LD for scaling.
	always_ff @(posedge clk) begin
		if (st_q == ST_RD_B) a_q <= rdata;
		if (st_q == ST_LD_B) b_q <= rdata;
		if (st_q == ST_OPS) begin
			mx_q <= zeta;
			my_q <= inv_q ? dif : b_q;
		end
		if (st_q == ST_SC_LD) begin
			mx_q <= INV_128;
			my_q <= rdata;
		end
	end

	assign out_valid   = ov_v_q;
	assign coeff_out   = ov_q;
	assign result_kind = kind_q;
endmodule

// ----- rtl/knt_checker.sv -----
// Port-level checker for the NTT block and its bind.
`include "kyber_ntt_forward_inverse_top_assert.svh"
module knt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] coeff_out,
	input logic        result_kind
);
	`KNT_ASSERT_IMP(a_done_zero, clk, arst_n, out_valid && result_kind, coeff_out == 12'd0)
	`KNT_ASSERT_IMP(a_canon, clk, arst_n, out_valid, coeff_out < 12'd3329)
	`KNT_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(coeff_out))
	`KNT_ASSERT_IMP(a_busy, clk, arst_n, out_valid, !in_ready)
endmodule

bind kyber_ntt_forward_inverse_top knt_checker u_knt_checker (.*);
